FILE: design/kde_pkg.sv
// shared types and constants for the keypad debounce encoder
package kde_pkg;

   localparam int unsigned NUM_KEYS  = 7;
   localparam int unsigned POWER_BIT = 7;

   // csr register indexes
   localparam logic [1:0] CSR_KEY_DEBOUNCE   = 2'd0;
   localparam logic [1:0] CSR_POWER_DEBOUNCE = 2'd1;
   localparam logic [1:0] CSR_STARTUP_LOCK   = 2'd2;

   // csr reset values
   localparam logic [7:0]  KEY_DEBOUNCE_RESET   = 8'd4;
   localparam logic [7:0]  POWER_DEBOUNCE_RESET = 8'd50;
   localparam logic [15:0] STARTUP_LOCK_RESET   = 16'd250;

   // key codes
   localparam logic [3:0] KEY_NONE  = 4'd0;
   localparam logic [3:0] KEY_UP    = 4'd1;
   localparam logic [3:0] KEY_ENTER = 4'd2;
   localparam logic [3:0] KEY_DOWN  = 4'd3;
   localparam logic [3:0] KEY_F5    = 4'd5;
   localparam logic [3:0] KEY_LEFT  = 4'd6;
   localparam logic [3:0] KEY_RIGHT = 4'd7;
   localparam logic [3:0] KEY_REC   = 4'd9;

   // pin positions
   localparam int unsigned PIN_LEFT  = 0;
   localparam int unsigned PIN_RIGHT = 1;
   localparam int unsigned PIN_UP    = 2;
   localparam int unsigned PIN_DOWN  = 3;
   localparam int unsigned PIN_ENTER = 4;
   localparam int unsigned PIN_F5    = 5;
   localparam int unsigned PIN_REC   = 6;

   typedef struct packed {
      logic [7:0] pin_levels;
      logic       record_active;
   } req_type;

   typedef struct packed {
      logic [3:0] key_code;
      logic       power_led;
      logic       power_off;
   } rsp_type;

   typedef struct packed {
      logic press;
      logic release_evt;
   } btn_event_type;

   // priority: rec, f5, enter, down, up, right, left
   function automatic logic [3:0] encode_keys(input logic [NUM_KEYS-1:0] press);
      logic [3:0] code;
      code = KEY_NONE;
      if (press[PIN_REC])        code = KEY_REC;
      else if (press[PIN_F5])    code = KEY_F5;
      else if (press[PIN_ENTER]) code = KEY_ENTER;
      else if (press[PIN_DOWN])  code = KEY_DOWN;
      else if (press[PIN_UP])    code = KEY_UP;
      else if (press[PIN_RIGHT]) code = KEY_RIGHT;
      else if (press[PIN_LEFT])  code = KEY_LEFT;
      return code;
   endfunction

endpackage

FILE: design/kde_debounce_cell.sv
// counter-based debounce for one button
module kde_debounce_cell
   import kde_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  logic          sample,
   input  logic [7:0]    threshold,
   output btn_event_type event_out
);

   localparam int unsigned CMP_WIDTH = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   logic                   level_ff, level_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [COUNT_WIDTH-1:0] count_inc;
   logic                   differ;
   logic                   hit;

   always_comb begin
      differ    = (sample != level_ff);
      count_inc = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
      hit       = (CMP_WIDTH'(count_inc) >= CMP_WIDTH'(threshold));
      level_in  = level_ff;
      count_in  = count_ff;
      if (enable) begin
         if (!differ) begin
            count_in = '0;
         end else if (hit) begin
            level_in = sample;
            count_in = '0;
         end else begin
            count_in = count_inc;
         end
      end
      event_out.press       = enable & differ & hit & sample;
      event_out.release_evt = enable & differ & hit & ~sample;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         level_ff <= level_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: design/kde_rsp_queue.sv
// two-entry result queue between the datapath and the rsp channel
module kde_rsp_queue
   import kde_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    has_room,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   rsp_type    head_ff, head_in;
   rsp_type    tail_ff, tail_in;
   logic [1:0] fill_ff, fill_in;
   logic       pop;

   assign has_room  = ~fill_ff[1];
   assign rsp_valid = (fill_ff != 2'd0);
   assign rsp_data  = head_ff;
   assign pop       = rsp_valid & rsp_ready;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (push && !pop) begin
         if (fill_ff == 2'd0) head_in = push_data;
         else                 tail_in = push_data;
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         head_in = tail_ff;
         fill_in = fill_ff - 2'd1;
      end else if (push && pop) begin
         // only possible with one entry held
         head_in = push_data;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
      if (reset) begin
         fill_ff <= 2'd0;
      end else begin
         fill_ff <= fill_in;
      end
   end

endmodule

FILE: design/keypad_debounce_encoder.sv
// keypad debounce encoder top level
//
// each req beat is one sample tick of eight active-low button pins (left,
// right, up, down, enter, f5, rec, power) plus a recording flag, and yields
// exactly one rsp beat. every button has its own level flop and saturating
// change counter; a sample differing from the stable level counts up, an
// equal one clears the counter, and reaching the threshold flips the level.
// a debounced key press gives a one-beat key code (rec wins, then f5, enter,
// down, up, right, left). the power button has its own threshold, drives the
// led, and its press waits while recording. once the startup tick count
// exceeds the lockout register, a handled power press latches power_off and
// the block halts: later beats return code 0, the held led and power_off.
// one beat per cycle while req_ready is high. until the halt, button state
// updates as a beat is taken; results go to a two-entry queue, so req_ready
// stays high while at most one is unread. the user must write thresholds
// through the csr port only while the block is idle; it is not enforced.
module keypad_debounce_encoder
   import kde_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   // sample ticks
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   // results
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   // csr write port
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // csr registers
   logic [7:0]  key_thr_ff;
   logic [7:0]  pwr_thr_ff;
   logic [15:0] lockout_ff;

   // block state
   logic        pending_ff, pending_in;
   logic        led_ff, led_in;
   logic [15:0] ticks_ff, ticks_in;
   logic        halted_ff, halted_in;

   logic          take;
   logic          step;
   logic [7:0]    pressed;
   btn_event_type evt [8];
   logic [NUM_KEYS-1:0] key_press;
   logic          pend_after;
   logic          handle;
   logic          turn_off;
   rsp_type       result;

   assign take    = req_valid & req_ready;
   assign step    = take & ~halted_ff;
   assign pressed = ~req_data.pin_levels;

   // seven keys share one threshold
   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
      kde_debounce_cell #(
         .COUNT_WIDTH(COUNT_WIDTH)
      ) u_key (
         .clock    (clock),
         .reset    (reset),
         .enable   (step),
         .sample   (pressed[k]),
         .threshold(key_thr_ff),
         .event_out(evt[k])
      );
      assign key_press[k] = evt[k].press;
   end

   kde_debounce_cell #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_power (
      .clock    (clock),
      .reset    (reset),
      .enable   (step),
      .sample   (pressed[POWER_BIT]),
      .threshold(pwr_thr_ff),
      .event_out(evt[POWER_BIT])
   );

   always_comb begin
      // led follows power press and release
      if (evt[POWER_BIT].press)            led_in = 1'b1;
      else if (evt[POWER_BIT].release_evt) led_in = 1'b0;
      else                                 led_in = led_ff;

      // pending press is checked against the tick count before it advances
      pend_after = pending_ff | evt[POWER_BIT].press;
      handle     = pend_after & ~req_data.record_active;
      turn_off   = handle & (ticks_ff > lockout_ff);

      pending_in = pending_ff;
      ticks_in   = ticks_ff;
      halted_in  = halted_ff;
      if (step) begin
         pending_in = handle ? 1'b0 : pend_after;
         halted_in  = turn_off;
         if (!turn_off && ticks_ff != 16'hFFFF) begin
            ticks_in = ticks_ff + 16'd1;
         end
      end

      if (halted_ff) begin
         result.key_code  = KEY_NONE;
         result.power_led = led_ff;
         result.power_off = 1'b1;
      end else if (turn_off) begin
         result.key_code  = KEY_NONE;
         result.power_led = led_in;
         result.power_off = 1'b1;
      end else begin
         result.key_code  = encode_keys(key_press);
         result.power_led = led_in;
         result.power_off = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_thr_ff <= KEY_DEBOUNCE_RESET;
         pwr_thr_ff <= POWER_DEBOUNCE_RESET;
         lockout_ff <= STARTUP_LOCK_RESET;
         pending_ff <= 1'b0;
         led_ff     <= 1'b0;
         ticks_ff   <= 16'd0;
         halted_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_KEY_DEBOUNCE:   key_thr_ff <= csr_wdata[7:0];
               CSR_POWER_DEBOUNCE: pwr_thr_ff <= csr_wdata[7:0];
               CSR_STARTUP_LOCK:   lockout_ff <= csr_wdata;
               default:            ;
            endcase
         end
         if (step) begin
            led_ff <= led_in;
         end
         pending_ff <= pending_in;
         ticks_ff   <= ticks_in;
         halted_ff  <= halted_in;
      end
   end

   // result queue decouples the rsp side
   kde_rsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (take),
      .push_data(result),
      .has_room (req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule
